// ===== sv/dtc_pkg.sv =====
`timescale 1ns / 1ps
package dtc_pkg;

    localparam int AddrW = 6;

    // register byte addresses, one 8-byte slot per register
    localparam logic [AddrW-1:0] ADDR_USE_TRIPLE   = 6'd0;
    localparam logic [AddrW-1:0] ADDR_DECRYPT_MODE = 6'd8;
    localparam logic [AddrW-1:0] ADDR_KEY_ONE      = 6'd16;
    localparam logic [AddrW-1:0] ADDR_KEY_TWO      = 6'd24;
    localparam logic [AddrW-1:0] ADDR_KEY_THREE    = 6'd32;
    localparam logic [AddrW-1:0] ADDR_INIT_VECTOR  = 6'd40;
    localparam logic [AddrW-1:0] ADDR_SEG_BYTES    = 6'd48;

    // control between sequencer and round unit
    typedef struct packed {
        logic load;      // load new block and key
        logic step;      // run one round
        logic inverse;   // decrypt key schedule
        logic [3:0] rnd; // round number
    } dtc_ctl_t;

    // S-boxes S1..S8, each indexed by row * 16 + column
    localparam int unsigned DES_SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [3:0] sbox(input logic [2:0] n, input logic [5:0] b);
        logic [1:0] row;
        logic [3:0] col;
        row = {b[5], b[0]};
        col = b[4:1];
        return 4'(DES_SBOX[n][{row, col}]);
    endfunction

endpackage

// ===== sv/des_tdea_cfb_cipher_core.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Ports            | Beat contents
// s_      | in  | s_t*, s_tuser    | tdata[63:0] segment_in, tuser[0] start_message
// m_      | out | m_t*             | tdata[63:0] segment_out
// cfg     | in  | APB p*           | 8-byte register slots, 64-bit data
// Each DES pass is a load and 16 rounds on the shared round unit; after the
// last pass, ST_OUT forms the result in out_reg before m_tvalid rises.
// Reset (aresetn low, synchronous) clears control, config registers and the feedback.
// s_tready is low from acceptance until the result beat is taken; m_tready
// stalls lengthen that time.
module des_tdea_cfb_cipher_core
    import dtc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // [63:0] segment_in
    input  logic             s_tuser,   // [0] start_message
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // [63:0] segment_out
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    localparam logic [1:0] ST_IDLE = 2'd0, ST_LOAD = 2'd1, ST_RUN = 2'd2, ST_OUT = 2'd3;

    logic        use_triple_reg, decrypt_mode_reg;
    logic [63:0] key_one_reg, key_two_reg, key_three_reg, init_vector_reg;
    logic [3:0]  segment_bytes_reg;
    logic [1:0]  state_reg, state_next;
    logic [3:0]  rnd_reg, rnd_next;
    logic [1:0]  pass_reg, pass_next;
    logic [63:0] fb_reg, fb_next, seg_reg, seg_next, out_reg, out_next, blk_reg, blk_next;
    logic        wr;
    logic [63:0] key_sel, blk_out, mask, ks_top, res, ct;
    logic [63:0] blk_src;
    logic [6:0]  bits;
    dtc_ctl_t    ctl;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_triple_reg <= 1'b0;
            decrypt_mode_reg <= 1'b0;
            key_one_reg <= '0;
            key_two_reg <= '0;
            key_three_reg <= '0;
            init_vector_reg <= '0;
            segment_bytes_reg <= 4'd1;
        end else if (wr) begin
            case (paddr)
                ADDR_USE_TRIPLE:   use_triple_reg <= pwdata[0];
                ADDR_DECRYPT_MODE: decrypt_mode_reg <= pwdata[0];
                ADDR_KEY_ONE:      key_one_reg <= pwdata;
                ADDR_KEY_TWO:      key_two_reg <= pwdata;
                ADDR_KEY_THREE:    key_three_reg <= pwdata;
                ADDR_INIT_VECTOR:  init_vector_reg <= pwdata;
                ADDR_SEG_BYTES:    segment_bytes_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_USE_TRIPLE:   prdata = {63'd0, use_triple_reg};
            ADDR_DECRYPT_MODE: prdata = {63'd0, decrypt_mode_reg};
            ADDR_KEY_ONE:      prdata = key_one_reg;
            ADDR_KEY_TWO:      prdata = key_two_reg;
            ADDR_KEY_THREE:    prdata = key_three_reg;
            ADDR_INIT_VECTOR:  prdata = init_vector_reg;
            ADDR_SEG_BYTES:    prdata = {60'd0, segment_bytes_reg};
            default:           prdata = '0;
        endcase
    end

    // segment width and mask
    always_comb begin
        case (segment_bytes_reg)
            4'd2:    bits = 7'd16;
            4'd4:    bits = 7'd32;
            4'd8:    bits = 7'd64;
            default: bits = 7'd8;
        endcase
        case (bits)
            7'd16:   mask = 64'h0000_0000_0000_FFFF;
            7'd32:   mask = 64'h0000_0000_FFFF_FFFF;
            7'd64:   mask = '1;
            default: mask = 64'h0000_0000_0000_00FF;
        endcase
        case (bits)
            7'd16:   ks_top = {48'd0, blk_out[63:48]};
            7'd32:   ks_top = {32'd0, blk_out[63:32]};
            7'd64:   ks_top = blk_out;
            default: ks_top = {56'd0, blk_out[63:56]};
        endcase
        res = (seg_reg ^ ks_top) & mask;
        ct = decrypt_mode_reg ? seg_reg : res;
        key_sel = (pass_reg == 2'd1) ? key_two_reg : (pass_reg == 2'd2) ? key_three_reg : key_one_reg;
        ctl.load = (state_reg == ST_LOAD);
        ctl.step = (state_reg == ST_RUN);
        ctl.inverse = (pass_reg == 2'd1);
        ctl.rnd = rnd_reg;
    end

    // intermediate pass input is the previous pass output, taken at load time
    assign blk_src = (state_reg == ST_LOAD && pass_reg != 2'd0) ? blk_out : blk_reg;

    dtc_round u_round (
        .aclk   (aclk),
        .key    (key_sel),
        .blk_in (blk_src),
        .ctl    (ctl),
        .blk_out(blk_out)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        pass_next = pass_reg;
        fb_next = fb_reg;
        seg_next = seg_reg;
        out_next = out_reg;
        blk_next = blk_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    seg_next = s_tdata & mask;
                    if (s_tuser) fb_next = init_vector_reg;
                    blk_next = s_tuser ? init_vector_reg : fb_reg;
                    pass_next = 2'd0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                rnd_next = 4'd0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd15) begin
                    state_next = ST_LOAD;
                    rnd_next = 4'd0;
                    pass_next = pass_reg + 2'd1;
                    if (!use_triple_reg || pass_reg == 2'd2) begin
                        // last pass: result is formed in the first ST_OUT cycle
                        state_next = ST_OUT;
                        pass_next = 2'd3;
                    end
                end
            end
            default: begin
                if (pass_reg == 2'd3) begin
                    out_next = res;
                    fb_next = (bits == 7'd64) ? ct : ((fb_reg << bits) | ct);
                    pass_next = 2'd0;
                end else if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg <= 4'd0;
            pass_reg <= 2'd0;
            fb_reg <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            pass_reg <= pass_next;
            fb_reg <= fb_next;
        end
        seg_reg <= seg_next;
        out_reg <= out_next;
        blk_reg <= blk_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT) && (pass_reg != 2'd3);
    assign m_tdata = out_reg;

    // no input taken while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");
    // accepted beat moves the sequencer into a load
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_LOAD)) else $error("no load after accept");
    // round counter is back at zero whenever the sequencer is in ST_OUT
    a_rnd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (rnd_reg == 4'd0)) else $error("round count stray");
endmodule

// ===== sv/dtc_round.sv =====
`timescale 1ns / 1ps
// one DES round per cycle while ctl.step is high, with its own key schedule registers
module dtc_round
    import dtc_pkg::*;
(
    input  logic              aclk,
    input  logic [63:0]       key,
    input  logic [63:0]       blk_in,
    input  dtc_ctl_t          ctl,
    output logic [63:0]       blk_out
);
    localparam logic [6:0] IP [64] = '{
        7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
        7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
        7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};
    localparam logic [6:0] FP [64] = '{
        7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
        7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
        7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
        7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};
    localparam logic [5:0] E [48] = '{
        6'd32,6'd1,6'd2,6'd3,6'd4,6'd5,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd8,6'd9,6'd10,6'd11,
        6'd12,6'd13,6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,6'd20,6'd21,
        6'd22,6'd23,6'd24,6'd25,6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};
    localparam logic [5:0] P [32] = '{
        6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
        6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};
    localparam logic [6:0] PC1 [56] = '{
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
        7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
        7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};
    localparam logic [5:0] PC2 [48] = '{
        6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,6'd23,6'd19,6'd12,6'd4,
        6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,6'd41,6'd52,6'd31,6'd37,6'd47,6'd55,6'd30,6'd40,
        6'd51,6'd45,6'd33,6'd48,6'd44,6'd49,6'd39,6'd56,6'd34,6'd53,6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};
    // rounds with a single-bit shift (bit n = round n)
    localparam logic [15:0] ONE_SHIFT = 16'b1000_0001_0000_0011;

    logic [31:0] l_reg, r_reg, l_next, r_next;
    logic [27:0] c_reg, d_reg, c_next, d_next;
    logic [63:0] ip_w, pre_fp;
    logic [55:0] k56, cd;
    logic [47:0] sub, ex, x;
    logic [31:0] s, f;
    logic [27:0] c_rot, d_rot;
    logic        single;

    // initial and final permutations, key PC-1
    always_comb begin
        for (int i = 0; i < 64; i++) ip_w[63-i] = blk_in[64-IP[i]];
        for (int i = 0; i < 56; i++) k56[55-i] = key[64-PC1[i]];
        pre_fp = {r_reg, l_reg};
        for (int i = 0; i < 64; i++) blk_out[63-i] = pre_fp[64-FP[i]];
    end

    // key rotation for this round: left when encrypting; unrotated when decrypting
    always_comb begin
        single = ONE_SHIFT[ctl.rnd];
        if (!ctl.inverse) begin
            c_rot = single ? {c_reg[26:0], c_reg[27]} : {c_reg[25:0], c_reg[27:26]};
            d_rot = single ? {d_reg[26:0], d_reg[27]} : {d_reg[25:0], d_reg[27:26]};
            cd = {c_rot, d_rot};
        end else begin
            // decrypt: first subkey is the unrotated schedule end (= PC-1 value)
            c_rot = c_reg;
            d_rot = d_reg;
            cd = {c_reg, d_reg};
        end
        for (int i = 0; i < 48; i++) sub[47-i] = cd[56-PC2[i]];
        for (int i = 0; i < 48; i++) ex[47-i] = r_reg[32-E[i]];
        x = ex ^ sub;
        for (int i = 0; i < 8; i++) s[31-4*i -: 4] = sbox(3'(i), x[47-6*i -: 6]);
        for (int i = 0; i < 32; i++) f[31-i] = s[32-P[i]];
    end

    always_comb begin
        l_next = l_reg;
        r_next = r_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (ctl.load) begin
            l_next = ip_w[63:32];
            r_next = ip_w[31:0];
            c_next = k56[55:28];
            d_next = k56[27:0];
        end else if (ctl.step) begin
            l_next = r_reg;
            r_next = l_reg ^ f;
            if (!ctl.inverse) begin
                c_next = c_rot;
                d_next = d_rot;
            end else begin
                // step right by the shift of the encrypt round mirrored to this one
                c_next = ONE_SHIFT[4'd15 - ctl.rnd] ? {c_reg[0], c_reg[27:1]}
                                                    : {c_reg[1:0], c_reg[27:2]};
                d_next = ONE_SHIFT[4'd15 - ctl.rnd] ? {d_reg[0], d_reg[27:1]}
                                                    : {d_reg[1:0], d_reg[27:2]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        l_reg <= l_next;
        r_reg <= r_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end
endmodule
